>>> hdl/hdr_tone_map_gamma_unit_defines.svh
// ---------------------------------------------------------------------------
// hdr tone map gamma unit assertion macros
// shared concurrent assertion wrappers, removed when ASSERT_OFF is set
// ---------------------------------------------------------------------------
`ifndef HDR_TONE_MAP_GAMMA_UNIT_DEFINES_SVH
`define HDR_TONE_MAP_GAMMA_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// checked only out of reset
`define HTMG_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked at every edge, reset included
`define HTMG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HTMG_ASSERT(lbl, clk, rstn, prop, msg)
`define HTMG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> hdl/hdr_tmg_pkg.sv
// ---------------------------------------------------------------------------
// hdr tone map gamma package
// fixed point constants, tables and pipeline depths shared by all modules
// ---------------------------------------------------------------------------
`default_nettype none

package hdr_tmg_pkg;

    localparam int CHANNEL_BITS_DEF = 16;
    localparam int OUT_BITS_DEF     = 10;
    localparam int CFG_W            = 9;
    localparam int NUM_LANES        = 3;

    // internal fixed widths
    localparam int C_W   = 32;   // scaled channel, q8.24
    localparam int U_W   = 30;   // compressed argument, q.24
    localparam int T_W   = 21;   // curve output, q.16
    localparam int LOG_W = 22;   // signed log2, q.16
    localparam int ACC_W = 17;   // exp accumulator, q.16

    localparam logic [21:0] COMP_F     = 22'd3101671;
    localparam logic [17:0] LN2_OVER_F = 18'd245714;
    localparam logic [14:0] GAMMA_INV  = 15'd29789;
    localparam logic [16:0] LOG2_3P5   = 17'd118447;

    localparam int LOG2_ITERS = 16;
    localparam int LOG2_LAT   = 2 + LOG2_ITERS;
    localparam int EXP_STEPS  = 12;
    // s1..s4, log a, s5 s6, log b, s7 s8, exp steps, s9
    localparam int LANE_LAT   = 4 + LOG2_LAT + 2 + LOG2_LAT + 2 + EXP_STEPS + 1;

    typedef logic [15:0] gain_t;
    typedef logic [16:0] exp_step_t;

    // 2^(m/16 + 0.47393) in q2.14
    localparam gain_t GAIN [16] = '{
        16'd22756, 16'd23763, 16'd24815, 16'd25914,
        16'd27061, 16'd28259, 16'd29510, 16'd30817,
        16'd32181, 16'd33606, 16'd35094, 16'd36648,
        16'd38270, 16'd39964, 16'd41734, 16'd43582
    };

    // 2^(2^-i) in q.16, i = 1..12
    localparam exp_step_t EXP_STEP [EXP_STEPS] = '{
        17'd92682, 17'd77936, 17'd71468, 17'd68438,
        17'd66971, 17'd66250, 17'd65892, 17'd65714,
        17'd65625, 17'd65580, 17'd65558, 17'd65547
    };

endpackage

`default_nettype wire

>>> hdl/hdr_tone_map_gamma_unit.sv
// ---------------------------------------------------------------------------
// hdr tone map gamma unit
// per-pixel hdr tone mapping: exposure gain, log soft knee, gamma 1/2.2
// ---------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_axis    in         s_tvalid/s_tready  s_tdata: red, green, blue q8.8
//  m_axis    out        m_tvalid/m_tready  m_tdata: red, green, blue codes
//  cfg       in         cfg_valid/cfg_ready cfg_data: exposure_level
//
//  one pixel per clock while the output is not stalled; the depth is set by the
//  two sixteen-stage log2 squaring pipelines and the twelve exp stages
//  three identical lanes run side by side, one per color, then merge
//  a stalled output freezes the whole pipeline, s_tready drops with it
//  reset clears the valid chain, output valid and exposure level (0)
//  cfg_ready is always high; write only while the pipeline is empty
// ---------------------------------------------------------------------------
`default_nettype none
`include "hdr_tone_map_gamma_unit_defines.svh"

module hdr_tone_map_gamma_unit
    import hdr_tmg_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
    parameter int OUT_BITS     = OUT_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // red_in, green_in, blue_in from bit 0 up, zero filled
    input  wire logic [((NUM_LANES*CHANNEL_BITS+7)/8)*8-1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // red_out, green_out, blue_out from bit 0 up, zero filled
    output logic [((NUM_LANES*OUT_BITS+7)/8)*8-1:0] m_tdata,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CFG_W-1:0]    cfg_data
);

    localparam int OUT_DW = ((NUM_LANES * OUT_BITS + 7) / 8) * 8;

    logic                 en;
    logic [CFG_W-1:0]     level_reg;
    logic [LANE_LAT-1:0]  vld_reg;
    logic [OUT_BITS-1:0]  code [NUM_LANES];

    // exposure register, signed sixteenths of a stop
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            level_reg <= cfg_data;
        end
    end

    // item valid travels beside the lane payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LANE_LAT-2:0], s_tvalid};
        end
    end

    assign s_tready = en;

    // one lane per color
    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        hdr_tmg_lane #(.CHANNEL_BITS(CHANNEL_BITS), .OUT_BITS(OUT_BITS)) u_lane
        (
            .clk   (clk),
            .en    (en),
            .level (level_reg),
            .chan  (s_tdata[g*CHANNEL_BITS +: CHANNEL_BITS]),
            .code  (code[g])
        );
    end

    // output register and pipeline enable
    hdr_tmg_merge #(.OUT_BITS(OUT_BITS), .OUT_DW(OUT_DW)) u_merge
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pipe_valid (vld_reg[LANE_LAT-1]),
        .code       (code),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata),
        .en         (en)
    );

    `HTMG_ASSERT_ALWAYS(a_rst_no_out, clk, !rst_n |-> !m_tvalid, "output valid in reset")
    `HTMG_ASSERT(a_stall_backpressure, clk, rst_n, m_tvalid && !m_tready |-> !s_tready, "input taken while output stalled")
    `HTMG_ASSERT(a_accept_enters, clk, rst_n, s_tvalid && s_tready |=> vld_reg[0], "accepted item lost at entry")
    `HTMG_ASSERT(a_drain_empty, clk, rst_n, m_tvalid && m_tready && !vld_reg[LANE_LAT-1] |=> !m_tvalid, "item invented at output")

endmodule

`default_nettype wire

>>> hdl/hdr_tmg_log2.sv
// ---------------------------------------------------------------------------
// hdr tmg log2
// pipelined log2 in q.16: leading one, normalize, sixteen squaring stages
// ---------------------------------------------------------------------------
`default_nettype none

module hdr_tmg_log2
    import hdr_tmg_pkg::*;
#(
    parameter int W      = 30,
    parameter int FB     = 24,
    parameter int SIDE_W = 1
)
(
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic [W-1:0]            x,
    input  wire logic [SIDE_W-1:0]       side_in,
    output logic signed [LOG_W-1:0]      log_out,
    output logic [SIDE_W-1:0]            side_out
);

    localparam int P_W = 5;

    logic [P_W-1:0]    pa_reg;
    logic [W-1:0]      xa_reg;
    logic [SIDE_W-1:0] sa_reg;
    logic [P_W-1:0]    pa_next;

    logic [30:0]       mant_reg [LOG2_ITERS+1];
    logic [15:0]       frac_reg [LOG2_ITERS+1];
    logic [P_W-1:0]    p_reg    [LOG2_ITERS+1];
    logic [SIDE_W-1:0] side_reg [LOG2_ITERS+1];

    logic signed [5:0] ip;

    // leading one
    always_comb
    begin
        pa_next = '0;
        for (int i = 0; i < W; i++)
        begin
            if (x[i])
            begin
                pa_next = P_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg      <= pa_next;
            xa_reg      <= x;
            sa_reg      <= side_in;
            // normalize to q1.30
            mant_reg[0] <= 31'(31'(xa_reg) << (P_W'(30) - pa_reg));
            frac_reg[0] <= '0;
            p_reg[0]    <= pa_reg;
            side_reg[0] <= sa_reg;
        end
    end

    for (genvar g = 0; g < LOG2_ITERS; g++)
    begin : g_sq
        logic [61:0] sq;
        logic [31:0] m2;
        assign sq = 62'(mant_reg[g]) * 62'(mant_reg[g]);
        assign m2 = sq[61:30];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mant_reg[g+1] <= m2[31] ? m2[31:1] : m2[30:0];
                frac_reg[g+1] <= {frac_reg[g][14:0], m2[31]};
                p_reg[g+1]    <= p_reg[g];
                side_reg[g+1] <= side_reg[g];
            end
        end
    end

    assign ip       = $signed(6'(p_reg[LOG2_ITERS]) - 6'(FB));
    assign log_out  = {ip, frac_reg[LOG2_ITERS]};
    assign side_out = side_reg[LOG2_ITERS];

endmodule

`default_nettype wire

>>> hdl/hdr_tmg_lane.sv
// ---------------------------------------------------------------------------
// hdr tmg lane
// one color channel: exposure, soft knee, gamma 1/2.2, scale and quantize
// ---------------------------------------------------------------------------
`default_nettype none

module hdr_tmg_lane
    import hdr_tmg_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
    parameter int OUT_BITS     = OUT_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic [CFG_W-1:0]        level,
    input  wire logic [CHANNEL_BITS-1:0] chan,
    output logic [OUT_BITS-1:0]          code
);

    localparam int PW = CHANNEL_BITS + 16;
    localparam int WW = PW + 19;
    localparam int PB = ACC_W + OUT_BITS;
    localparam logic [OUT_BITS-1:0] MAXC = '1;

    logic [CFG_W-1:0] biased;
    logic [PW-1:0]    p_reg;
    logic [4:0]       rs_reg;

    logic [WW-1:0]    wide;
    logic [C_W-1:0]   c_reg;

    logic [C_W-1:0]   cm1;
    logic [53:0]      fprod_reg;
    logic [16:0]      small_t_reg;
    logic             big_reg;

    logic [U_W-1:0]   u_reg;
    logic [17:0]      side4_reg;
    logic [17:0]      side_a_in;
    logic [17:0]      side_a_out;
    logic signed [LOG_W-1:0] log_a;

    logic [36:0]      kprod_reg;
    logic [17:0]      side5_reg;
    logic [T_W-1:0]   t_reg;
    logic             zero6_reg;

    logic signed [LOG_W-1:0] log_b;
    logic             zero_b;

    logic signed [37:0] gprod_reg;
    logic             zero7_reg;

    logic signed [21:0] y;
    logic signed [23:0] z;
    logic signed [7:0]  n;

    logic [ACC_W-1:0] acc_reg  [EXP_STEPS+1];
    logic [15:0]      fr_reg   [EXP_STEPS+1];
    logic [7:0]       k_reg    [EXP_STEPS+1];
    logic             zero_reg [EXP_STEPS+1];
    logic             sat_reg  [EXP_STEPS+1];

    logic [PB-1:0]    mprod_reg;
    logic [7:0]       k9_reg;
    logic             zero9_reg;
    logic             sat9_reg;

    logic [PB:0]      rsum;
    logic [PB:0]      rq;

    assign biased = level ^ CFG_W'(9'h100);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // s1 gain mantissa, shift = q + 4
            p_reg     <= PW'(chan) * PW'(GAIN[biased[3:0]]);
            rs_reg    <= ~biased[8:4];
            // s2 exponent shift with saturation
            c_reg     <= (|wide[WW-1:C_W]) ? '1 : wide[C_W-1:0];
            // s3 knee product
            big_reg     <= c_reg > C_W'(32'h0100_0000);
            fprod_reg   <= 54'(cm1) * 54'(COMP_F);
            small_t_reg <= c_reg[24:8];
            // s4, knee flag and small curve ride beside u
            u_reg     <= U_W'(30'h0100_0000) + U_W'(fprod_reg >> 24);
            side4_reg <= {big_reg, small_t_reg};
            // s5 ln scale
            kprod_reg <= 37'(log_a[18:0]) * 37'(LN2_OVER_F);
            side5_reg <= side_a_out;
            // s6 curve select
            t_reg     <= side5_reg[17] ? T_W'(21'h10000 + 21'(kprod_reg >> 16))
                                       : T_W'(side5_reg[16:0]);
            zero6_reg <= side5_reg[17] ? 1'b0 : (side5_reg[16:0] == '0);
            // s7 gamma product
            gprod_reg <= 38'(log_b) * $signed({23'd0, GAMMA_INV});
            zero7_reg <= zero_b;
            // s8 exponent split
            acc_reg[0]  <= ACC_W'(17'h10000);
            fr_reg[0]   <= z[15:0];
            k_reg[0]    <= 8'(8'sd16 - n);
            zero_reg[0] <= zero7_reg;
            sat_reg[0]  <= !z[23];
            // s9 output scale
            mprod_reg <= PB'(acc_reg[EXP_STEPS]) * PB'(MAXC);
            k9_reg    <= k_reg[EXP_STEPS];
            zero9_reg <= zero_reg[EXP_STEPS];
            sat9_reg  <= sat_reg[EXP_STEPS];
        end
    end

    assign wide      = WW'({p_reg, 19'd0}) >> rs_reg;
    assign cm1       = c_reg - C_W'(32'h0100_0000);
    assign side_a_in = side4_reg;
    assign y         = 22'(gprod_reg >>> 16);
    assign z         = 24'(y) - $signed({7'd0, LOG2_3P5});
    assign n         = 8'(z >>> 16);

    hdr_tmg_log2 #(.W(U_W), .FB(24), .SIDE_W(18)) u_log_a
    (
        .clk      (clk),
        .en       (en),
        .x        (u_reg),
        .side_in  (side_a_in),
        .log_out  (log_a),
        .side_out (side_a_out)
    );

    hdr_tmg_log2 #(.W(T_W), .FB(16), .SIDE_W(1)) u_log_b
    (
        .clk      (clk),
        .en       (en),
        .x        (t_reg),
        .side_in  (zero6_reg),
        .log_out  (log_b),
        .side_out (zero_b)
    );

    // 2^frac, one fraction bit per stage
    for (genvar g = 0; g < EXP_STEPS; g++)
    begin : g_exp
        logic [33:0] mul;
        assign mul = 34'(acc_reg[g]) * 34'(EXP_STEP[g]) + 34'd32768;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[g+1]  <= fr_reg[g][15-g] ? ACC_W'(mul >> 16) : acc_reg[g];
                fr_reg[g+1]   <= fr_reg[g];
                k_reg[g+1]    <= k_reg[g];
                zero_reg[g+1] <= zero_reg[g];
                sat_reg[g+1]  <= sat_reg[g];
            end
        end
    end

    assign rsum = (PB+1)'(mprod_reg) + ((PB+1)'(1) << (k9_reg - 8'd1));
    assign rq   = rsum >> k9_reg;

    always_comb
    begin
        if (zero9_reg)
        begin
            code = '0;
        end
        else if (sat9_reg)
        begin
            code = MAXC;
        end
        else if (k9_reg > 8'(PB))
        begin
            code = '0;
        end
        else if (rq > (PB+1)'(MAXC))
        begin
            code = MAXC;
        end
        else
        begin
            code = OUT_BITS'(rq);
        end
    end

endmodule

`default_nettype wire

>>> hdl/hdr_tmg_merge.sv
// ---------------------------------------------------------------------------
// hdr tmg merge
// joins the lane codes into one output item and holds it until taken
// ---------------------------------------------------------------------------
`default_nettype none

module hdr_tmg_merge
    import hdr_tmg_pkg::*;
#(
    parameter int OUT_BITS = OUT_BITS_DEF,
    parameter int OUT_DW   = ((NUM_LANES * OUT_BITS + 7) / 8) * 8
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                pipe_valid,
    input  wire logic [OUT_BITS-1:0] code [NUM_LANES],
    input  wire logic                m_tready,
    output logic                     m_tvalid,
    output logic [OUT_DW-1:0]        m_tdata,
    output logic                     en
);

    logic                    valid_reg;
    logic [OUT_DW-1:0]       data_reg;
    logic [OUT_DW-1:0]       data_next;

    assign en = !valid_reg || m_tready;

    always_comb
    begin
        data_next = '0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            data_next[i*OUT_BITS +: OUT_BITS] = code[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= pipe_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

`default_nettype wire

>>> tb/tb_hdr_tone_map_gamma_unit.sv
// ---------------------------------------------------------------------------
// hdr tone map gamma unit testbench
// drives pixels through the stream ports with random idling and a long output
// hold-off, predicts each tone-mapped pixel and compares it field by field
// ---------------------------------------------------------------------------
`default_nettype none

module tb_hdr_tone_map_gamma_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import hdr_tmg_pkg::*;

    localparam int IN_W      = ((NUM_LANES*CHANNEL_BITS_DEF+7)/8)*8;
    localparam int OUT_W     = ((NUM_LANES*OUT_BITS_DEF+7)/8)*8;
    localparam int RAND_PIX  = 1000;
    localparam int MAX_CYC   = 400000;
    localparam int DRAIN_CYC = LANE_LAT + 20;
    localparam int NUM_DIR   = 20;
    localparam logic [9:0] FULL = 10'd1023;
    localparam logic [9:0] NONE = 10'h3FF; // unused marker, expected column blank

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [9:0] red;
        logic [9:0] green;
        logic [9:0] blue;
    } codes_t;

    // directed row: pixel, plus a typed expectation where obvious
    typedef struct packed {
        pixel_t     pix;
        logic       known;
        logic [9:0] code;   // all three channels expected equal to this
    } row_t;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;   // red_in, green_in, blue_in from bit 0 up
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;   // red_out, green_out, blue_out from bit 0 up
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    // exposure copy used by the predictor
    logic signed [8:0] exposure;

    codes_t pending_codes[$];
    int     mismatches;
    int     cycles;
    bit     hold_off_req;
    bit     hold_off_done;
    bit     calm;            // no idling on either side
    row_t   rows [NUM_DIR];

    hdr_tone_map_gamma_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------
    function automatic int unsigned gain_mant(int m);
        int unsigned g [16];
        g = '{22756, 23763, 24815, 25914, 27061, 28259, 29510, 30817,
              32181, 33606, 35094, 36648, 38270, 39964, 41734, 43582};
        return g[m];
    endfunction

    function automatic longint unsigned exp_factor(int i);
        longint unsigned e [12];
        e = '{92682, 77936, 71468, 68438, 66971, 66250,
              65892, 65714, 65625, 65580, 65558, 65547};
        return e[i];
    endfunction

    // log2 in q.16 of x with fb fractional bits, by mantissa squaring
    function automatic longint log2_q16(longint unsigned x, int fb);
        int              lead;
        longint unsigned mant;
        longint          frac;
        lead = 63;
        frac = 0;
        while (lead > 0 && x[lead] == 1'b0)
            lead--;
        mant = (lead >= 30) ? (x >> (lead - 30)) : (x << (30 - lead));
        for (int i = 0; i < 16; i++)
        begin
            mant = (mant * mant) >> 30;
            frac = frac << 1;
            if (mant >= (64'd1 << 31))
            begin
                frac = frac | 1;
                mant = mant >> 1;
            end
        end
        return longint'(lead - fb) * 65536 + frac;
    endfunction

    function automatic longint floor_div16(longint v);
        if (v >= 0)
            return v / 65536;
        return -((-v + 65535) / 65536);
    endfunction

    function automatic logic [9:0] tone_map_channel(logic [15:0] chan, int q, int m);
        longint unsigned prod, scaled, knee, curve, acc, lu;
        longint          y, z, n, fr;
        int              sh, k;
        prod = longint'(chan) * gain_mant(m);
        sh   = q + 4;
        if (sh >= 0)
            scaled = (prod > (64'hFFFF_FFFF >> sh)) ? 64'hFFFF_FFFF : (prod << sh);
        else
        begin
            scaled = prod >> (-sh);
            if (scaled > 64'hFFFF_FFFF)
                scaled = 64'hFFFF_FFFF;
        end
        // soft knee above 1.0
        if (scaled > (64'd1 << 24))
        begin
            knee  = (64'd1 << 24) + (((scaled - (64'd1 << 24)) * 64'd3101671) >> 24);
            lu    = longint'(log2_q16(knee, 24));
            curve = 65536 + ((lu * 64'd245714) >> 16);
        end
        else
            curve = scaled >> 8;
        if (curve == 0)
            return '0;
        y = floor_div16(log2_q16(curve, 16) * 29789);
        z = y - 118447;
        if (z >= 0)
            return FULL;
        n   = floor_div16(z);
        fr  = z - n * 65536;
        acc = 65536;
        for (int i = 0; i < 12; i++)
            if (fr[15 - i])
                acc = (acc * exp_factor(i) + 32768) >> 16;
        if (-n >= 47)
            return '0;
        k    = 16 + int'(-n);
        prod = acc * 1023;
        prod = (prod + (64'd1 << (k - 1))) >> k;
        if (prod > 1023)
            prod = 1023;
        return prod[9:0];
    endfunction

    function automatic codes_t tone_map_pixel(pixel_t pix);
        codes_t c;
        int     q;
        int     m;
        q = (int'(exposure) >>> 4);
        m = int'(exposure) & 15;
        c.red   = tone_map_channel(pix.red, q, m);
        c.green = tone_map_channel(pix.green, q, m);
        c.blue  = tone_map_channel(pix.blue, q, m);
        return c;
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------
    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 36);
    endfunction

    function automatic logic [15:0] rand_channel();
        case ($urandom_range(5))
            0:       return 16'($urandom_range(255));     // below one
            1:       return 16'($urandom_range(1023));
            2:       return 16'hFFFF - 16'($urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    // valid stays up after an accept; the next call or the caller drops it
    task automatic send_pixel(pixel_t pix, bit known, logic [9:0] code);
        codes_t c;
        while (idle_now())
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        c = tone_map_pixel(pix);
        if (known && c != {code, code, code})
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row %h: predictor %h, typed %h", pix, c, code);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({pix.blue, pix.green, pix.red});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_codes.push_back(c);
        @(negedge clk);
    endtask

    // exposure written only with the pipeline empty
    task automatic write_exposure(logic signed [8:0] lvl);
        s_tvalid <= 1'b0;
        while (pending_codes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= lvl;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        exposure = lvl;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver: random idling, plus one long hold-off on request
    initial
    begin
        int hold;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                m_tready <= 1'b0;
                for (hold = 0; hold < 3 * LANE_LAT + 40; hold++)
                    @(negedge clk);
                hold_off_done = 1'b1;
            end
            m_tready <= !idle_now();
        end
    end

    // output checker
    always @(posedge clk)
    begin
        codes_t got;
        codes_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[9:0], m_tdata[19:10], m_tdata[29:20]};
            if (pending_codes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel out: %h", got);
            end
            else
            begin
                want = pending_codes.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel mismatch: expected r %0d g %0d b %0d, got r %0d g %0d b %0d",
                                 want.red, want.green, want.blue,
                                 got.red, got.green, got.blue);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYC)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        logic signed [8:0] lvls [6];
        pixel_t pix;
        mismatches = 0;
        cycles     = 0;
        calm       = 1'b0;
        exposure   = '0;
        hold_off_req  = 1'b0;
        hold_off_done = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;

        // directed table: zero, tiny, one, extremes, mixed channels
        rows[0]  = '{pix: '{16'h0000, 16'h0000, 16'h0000}, known: 1, code: 10'd0};
        rows[1]  = '{pix: '{16'hFFFF, 16'hFFFF, 16'hFFFF}, known: 0, code: NONE};
        rows[2]  = '{pix: '{16'h0001, 16'h0002, 16'h0004}, known: 0, code: NONE};
        rows[3]  = '{pix: '{16'h0100, 16'h0080, 16'h0040}, known: 0, code: NONE};
        rows[4]  = '{pix: '{16'h0000, 16'hFFFF, 16'h0100}, known: 0, code: NONE};
        rows[5]  = '{pix: '{16'hAAAA, 16'h5555, 16'hFF00}, known: 0, code: NONE};
        rows[6]  = '{pix: '{16'h00FF, 16'h7FFF, 16'h8000}, known: 0, code: NONE};
        rows[7]  = '{pix: '{16'h1000, 16'h0200, 16'h0010}, known: 0, code: NONE};
        for (int i = 8; i < NUM_DIR; i++)
            rows[i] = '{pix: '{16'd1 << (i - 8), 16'd1 << (i - 4), 16'd3 << (i - 8)},
                        known: 0, code: NONE};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset exposure, then the extremes of the register, -160, 160 and 7
        lvls = '{9'sd0, -9'sd256, 9'sd255, -9'sd160, 9'sd160, 9'sd7};
        for (int l = 0; l < 6; l++)
        begin
            if (l != 0)
                write_exposure(lvls[l]);
            for (int i = 0; i < NUM_DIR; i++)
                send_pixel(rows[i].pix, rows[i].known && l == 0, rows[i].code);
        end

        // random part: new exposure every so often, one calm stretch,
        // one long output hold-off with the sender pushing on
        for (int n = 0; n < RAND_PIX; n++)
        begin
            if (n % 125 == 0)
                write_exposure(9'(($urandom_range(3) == 0) ? $urandom
                                                           : $urandom_range(320) - 160));
            calm = (n >= 300 && n < 420);
            if (n == 500)
                hold_off_req = 1'b1;
            pix.red   = rand_channel();
            pix.green = rand_channel();
            pix.blue  = rand_channel();
            send_pixel(pix, 1'b0, NONE);
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_codes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
